[rtl/brf_pkg.sv]
// brf_pkg: shared types and constants of the chunked byte ring fifo
// used by brf_lane, brf_merge and byte_ring_fifo_chunked; no dependencies
`timescale 1ns / 1ps

package brf_pkg;

   // one byte lane per byte of a transaction
   localparam int LANE_COUNT   = 8;
   localparam int LANE_BITS    = 3;
   localparam int BYTE_W       = 8;
   localparam int DATA_W       = LANE_COUNT * BYTE_W;
   localparam int LEN_W        = 4;
   localparam int CNT_W        = 11;
   localparam int MAX_TRANSFER = 8;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // capacity after reset
   localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

   // per-lane control for one transaction
   typedef struct packed {
      logic             wr_go;
      logic             rd_go;
      logic [LEN_W-1:0] len;
   } lane_ctl_type;

endpackage

[rtl/brf_ram.sv]
// brf_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/brf_lane.sv]
// brf_lane: one byte lane of the ring, address generation and its ram bank
// depends on brf_pkg and brf_ram
`timescale 1ns / 1ps

module brf_lane #(
   parameter int LANE  = 0,
   parameter int PTR_W = 10
) (
   input  logic                          clock,
   input  brf_pkg::lane_ctl_type         ctl,
   input  logic [PTR_W-1:0]              wr_ptr,
   input  logic [PTR_W-1:0]              rd_ptr,
   input  logic [brf_pkg::DATA_W-1:0]    write_bytes,
   output logic [brf_pkg::BYTE_W-1:0]    rd_byte
);

   localparam int ROW_W = PTR_W - brf_pkg::LANE_BITS;
   localparam int ROWS  = 1 << ROW_W;

   logic [brf_pkg::LANE_BITS-1:0] wr_idx;
   logic [brf_pkg::LANE_BITS-1:0] rd_idx;
   logic [PTR_W-1:0]              wr_pos;
   logic [PTR_W-1:0]              rd_pos;
   logic [brf_pkg::DATA_W-1:0]    shifted;
   logic                          wr_en;
   logic                          rd_en;

   // byte index of the transaction that lands on this lane
   assign wr_idx = brf_pkg::LANE_BITS'(LANE) - wr_ptr[brf_pkg::LANE_BITS-1:0];
   assign rd_idx = brf_pkg::LANE_BITS'(LANE) - rd_ptr[brf_pkg::LANE_BITS-1:0];
   assign wr_pos = wr_ptr + PTR_W'(wr_idx);
   assign rd_pos = rd_ptr + PTR_W'(rd_idx);

   // pick this lane's byte out of the write word
   assign shifted = write_bytes >> {wr_idx, 3'b000};

   assign wr_en = ctl.wr_go && ({1'b0, wr_idx} < ctl.len);
   assign rd_en = ctl.rd_go;

   brf_ram #(
      .WIDTH(brf_pkg::BYTE_W),
      .DEPTH(ROWS)
   ) u_bank (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_pos[PTR_W-1:brf_pkg::LANE_BITS]),
      .wr_data(shifted[brf_pkg::BYTE_W-1:0]),
      .rd_en  (rd_en),
      .rd_addr(rd_pos[PTR_W-1:brf_pkg::LANE_BITS]),
      .rd_data(rd_byte)
   );

endmodule

[rtl/brf_merge.sv]
// brf_merge: rotates the lane read bytes into transaction order and masks
// the bytes past the length, or all bytes when not enabled; depends on brf_pkg
`timescale 1ns / 1ps

module brf_merge (
   input  logic                                 enable,
   input  logic [brf_pkg::LANE_BITS-1:0]        rot,
   input  logic [brf_pkg::LEN_W-1:0]            len,
   input  logic [brf_pkg::DATA_W-1:0]           lane_bytes,
   output logic [brf_pkg::DATA_W-1:0]           read_bytes
);

   // byte i comes from lane (rot + i) mod lane count
   always_comb begin
      logic [brf_pkg::LANE_BITS-1:0] src;
      read_bytes = '0;
      for (int i = 0; i < brf_pkg::LANE_COUNT; i++) begin
         src = rot + brf_pkg::LANE_BITS'(i);
         if (enable && (brf_pkg::LEN_W'(i) < len)) begin
            read_bytes[i*brf_pkg::BYTE_W +: brf_pkg::BYTE_W] =
               lane_bytes[src*brf_pkg::BYTE_W +: brf_pkg::BYTE_W];
         end
      end
   end

endmodule

[rtl/byte_ring_fifo_chunked.sv]
// byte_ring_fifo_chunked: circular byte fifo with all-or-nothing transfers
// and a high-water mark; depends on brf_pkg, brf_lane, brf_merge
`timescale 1ns / 1ps
//
//  port group  direction  handshake             payload
//  req_        in         req_valid/req_stall   command, transfer_length, write_bytes
//  rsp_        out        rsp_valid/rsp_stall   accepted, read_bytes, fill/free/peak
//  csr_        in         csr_wr_en             csr_wr_data (ring capacity)
//
//  one transaction per cycle unless the response stalls; a request passes the
//  registered read of the eight lane ram banks, then the response register
//  reset is synchronous: pointers, fill and peak clear, capacity goes to 1024
//  a stalled response holds the pipe; req_stall rises only when both the
//  lane read stage and the response register are full and rsp_stall is high

module byte_ring_fifo_chunked #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [brf_pkg::LEN_W-1:0]            req_transfer_length,
   input  logic [brf_pkg::DATA_W-1:0]           req_write_bytes,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [brf_pkg::DATA_W-1:0]           rsp_read_bytes,
   output logic [brf_pkg::CNT_W-1:0]            rsp_fill_level,
   output logic [brf_pkg::CNT_W-1:0]            rsp_free_space,
   output logic [brf_pkg::CNT_W-1:0]            rsp_peak_fill,
   input  logic                                 csr_wr_en,
   input  logic [brf_pkg::CNT_W-1:0]            csr_wr_data
);

   // physical pointers run over a power of two at least the ring depth
   localparam int PTR_W   = ($clog2(RING_DEPTH) < 4) ? 4 : $clog2(RING_DEPTH);
   localparam int CAP_MAX = (RING_DEPTH > 2047) ? 2047 : RING_DEPTH;
   localparam logic [brf_pkg::CNT_W-1:0] CAP_LIMIT = brf_pkg::CNT_W'(CAP_MAX);

   logic [brf_pkg::CNT_W-1:0]      cap_ff;
   logic [brf_pkg::CNT_W-1:0]      cap_use;
   logic [PTR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [brf_pkg::CNT_W-1:0]      fill_ff, fill_in;
   logic [brf_pkg::CNT_W-1:0]      peak_ff, peak_in;

   logic                           s1_valid_ff;
   logic                           s1_acc_ff;
   logic                           s1_rd_ff;
   logic [brf_pkg::LANE_BITS-1:0]  s1_rot_ff;
   logic [brf_pkg::LEN_W-1:0]      s1_len_ff;
   logic [brf_pkg::CNT_W-1:0]      s1_fill_ff;
   logic [brf_pkg::CNT_W-1:0]      s1_free_ff;
   logic [brf_pkg::CNT_W-1:0]      s1_peak_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_acc_ff;
   logic [brf_pkg::DATA_W-1:0]     rsp_data_ff;
   logic [brf_pkg::CNT_W-1:0]      rsp_fill_ff;
   logic [brf_pkg::CNT_W-1:0]      rsp_free_ff;
   logic [brf_pkg::CNT_W-1:0]      rsp_peak_ff;

   logic                           out_free;
   logic                           s1_free;
   logic                           req_take;
   logic                           len_ok;
   logic                           wr_ok;
   logic                           rd_ok;
   logic                           xfer_ok;
   logic [brf_pkg::CNT_W-1:0]      space;
   logic [brf_pkg::CNT_W-1:0]      len_ext;
   brf_pkg::lane_ctl_type          lane_ctl;
   logic [brf_pkg::DATA_W-1:0]     lane_bytes;
   logic [brf_pkg::DATA_W-1:0]     merged;

   // capacity in use, zero acts as one and large values clamp
   always_comb begin
      if (cap_ff == '0) begin
         cap_use = brf_pkg::CNT_W'(1);
      end else if (cap_ff > CAP_LIMIT) begin
         cap_use = CAP_LIMIT;
      end else begin
         cap_use = cap_ff;
      end
   end

   // flow control through lane read stage and response register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;

   // admission check against free space or fill
   assign len_ext = brf_pkg::CNT_W'(req_transfer_length);
   assign space   = cap_use - fill_ff;
   assign len_ok  = req_transfer_length <= brf_pkg::LEN_W'(brf_pkg::MAX_TRANSFER);
   assign wr_ok   = len_ok && (req_command == brf_pkg::CMD_WRITE) && (len_ext <= space);
   assign rd_ok   = len_ok && (req_command == brf_pkg::CMD_READ) && (len_ext <= fill_ff);
   assign xfer_ok = wr_ok || rd_ok;

   // next pointer, fill and peak
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      peak_in   = peak_ff;
      if (req_take && wr_ok) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(req_transfer_length);
         fill_in   = fill_ff + len_ext;
         if (fill_in > peak_ff) begin
            peak_in = fill_in;
         end
      end else if (req_take && rd_ok) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(req_transfer_length);
         fill_in   = fill_ff - len_ext;
      end
   end

   // ring state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= brf_pkg::CAP_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         peak_ff   <= '0;
      end else if (csr_wr_en) begin
         cap_ff    <= csr_wr_data;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         peak_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         peak_ff   <= peak_in;
      end
   end

   // lane control for this transaction
   always_comb begin
      lane_ctl.wr_go = req_take && wr_ok;
      lane_ctl.rd_go = req_take && rd_ok;
      lane_ctl.len   = req_transfer_length;
   end

   // byte lanes
   for (genvar l = 0; l < brf_pkg::LANE_COUNT; l++) begin : g_lane
      brf_lane #(
         .LANE (l),
         .PTR_W(PTR_W)
      ) u_lane (
         .clock      (clock),
         .ctl        (lane_ctl),
         .wr_ptr     (wr_ptr_ff),
         .rd_ptr     (rd_ptr_ff),
         .write_bytes(req_write_bytes),
         .rd_byte    (lane_bytes[l*brf_pkg::BYTE_W +: brf_pkg::BYTE_W])
      );
   end

   // lane read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   // lane read stage payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_acc_ff  <= xfer_ok;
         s1_rd_ff   <= rd_ok;
         s1_rot_ff  <= rd_ptr_ff[brf_pkg::LANE_BITS-1:0];
         s1_len_ff  <= req_transfer_length;
         s1_fill_ff <= fill_in;
         s1_free_ff <= cap_use - fill_in;
         s1_peak_ff <= peak_in;
      end
   end

   brf_merge u_merge (
      .enable    (s1_rd_ff),
      .rot       (s1_rot_ff),
      .len       (s1_len_ff),
      .lane_bytes(lane_bytes),
      .read_bytes(merged)
   );

   // response register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // response register payload
   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_acc_ff  <= s1_acc_ff;
         rsp_data_ff <= merged;
         rsp_fill_ff <= s1_fill_ff;
         rsp_free_ff <= s1_free_ff;
         rsp_peak_ff <= s1_peak_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_read_bytes = rsp_data_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_free_space = rsp_free_ff;
   assign rsp_peak_fill  = rsp_peak_ff;

   // fill never exceeds the capacity in use
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_use)
      else $error("fill above capacity");

   // peak is at least the current fill
   a_peak_fill: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= fill_ff)
      else $error("peak below fill");

   // a rejected transaction leaves the fill alone
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (req_take && !xfer_ok && !csr_wr_en) |=> (fill_ff == $past(fill_ff)))
      else $error("rejected transaction changed fill");

   // a rejected response carries no read bytes
   a_reject_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_acc_ff) |-> (rsp_data_ff == '0))
      else $error("rejected response with data");

endmodule
